[src/fhqs_pkg.sv]
// Shared types, constants and functions for the flow hash queue select block.
`timescale 1ns / 1ps
package fhqs_pkg;

	localparam int unsigned QUEUE_LIMIT = 16;
	localparam int unsigned QUEUE_SPAN  = 16;
	localparam int unsigned MSG_W       = 296;
	localparam int unsigned V4_BYTES    = 13;
	localparam int unsigned V6_BYTES    = 37;
	localparam int unsigned CNT_W       = 6;
	localparam int unsigned JOB_DEPTH   = 2;

	localparam logic [31:0] FNV_OFFSET  = 32'd2166136261;
	localparam logic [7:0]  V6_TAIL     = 8'd17;

	localparam logic MODE_V4 = 1'b0;
	localparam logic MODE_V6 = 1'b1;

	typedef struct packed {
		logic             v6;
		logic [MSG_W-1:0] msg;
	} job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HASH,
		B_MOD,
		B_DONE
	} back_state_t;

	// FNV-1a round: xor the byte in, multiply by 2^24 + 403.
	function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
	endfunction

endpackage

[src/fhqs_if.sv]
// Valid/ready channel interfaces for flow tuples and hash results.
`timescale 1ns / 1ps
interface fhqs_tuple_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] source_high;
	logic [63:0] source_low;
	logic [63:0] destination_high;
	logic [63:0] destination_low;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [7:0]  protocol;

	modport source (output valid, mode, source_high, source_low, destination_high,
		destination_low, src_port, dst_port, protocol, input ready);
	modport sink (input valid, mode, source_high, source_low, destination_high,
		destination_low, src_port, dst_port, protocol, output ready);
endinterface

interface fhqs_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] tuple_hash;
	logic [3:0]  queue;

	modport source (output valid, tuple_hash, queue, input ready);
	modport sink (input valid, tuple_hash, queue, output ready);
endinterface

[src/fhqs_front.sv]
// Front end: accepts tuples, packs the hashed byte stream and queues jobs.
`timescale 1ns / 1ps
module fhqs_front
	import fhqs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	fhqs_tuple_if.sink   tuple,
	output logic         head_valid,
	output job_t         head,
	input  logic         pop
);

	localparam int unsigned PtrW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int unsigned FillW = $clog2(JOB_DEPTH + 1);

	job_t               jobs_q [JOB_DEPTH];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [FillW-1:0]   fill_q;
	job_t               packed_job;
	logic               push;

	always_comb begin
		packed_job.v6 = tuple.mode;
		if (tuple.mode == MODE_V6) begin
			packed_job.msg = {tuple.source_high, tuple.source_low, tuple.destination_high,
				tuple.destination_low, tuple.src_port, tuple.dst_port, V6_TAIL};
		end else begin
			packed_job.msg = {tuple.source_low[31:0], tuple.destination_low[31:0],
				tuple.src_port, tuple.dst_port, tuple.protocol,
				{(MSG_W - 8 * V4_BYTES){1'b0}}};
		end
	end

	assign tuple.ready = (fill_q != FillW'(JOB_DEPTH));
	assign push        = tuple.valid && tuple.ready;
	assign head_valid  = (fill_q != '0);
	assign head        = jobs_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			jobs_q[wr_ptr_q] <= packed_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[src/fhqs_back.sv]
// Back end: hashes one byte per cycle, reduces modulo queue count, holds the result.
`timescale 1ns / 1ps
module fhqs_back
	import fhqs_pkg::*;
#(
	parameter int unsigned QueueLimit = QUEUE_LIMIT
)
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  job_t          head,
	output logic          pop,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_wdata,
	fhqs_result_if.source result
);

	localparam logic [4:0] CountCap = (QueueLimit > QUEUE_SPAN) ? 5'(QUEUE_SPAN)
	                                                            : 5'(QueueLimit);

	back_state_t        state_q;
	back_state_t        state_d;
	logic [4:0]         queue_count_q;
	logic [4:0]         count_eff;
	logic [MSG_W-1:0]   msg_q;
	logic [CNT_W-1:0]   left_q;
	logic [31:0]        hash_q;
	logic [31:0]        modsh_q;
	logic [1:0]         mstep_q;
	logic [3:0]         rem_q;
	logic [3:0]         rem_next;
	logic [31:0]        hash_next;
	logic               load;
	logic               out_valid_q;
	logic [31:0]        out_hash_q;
	logic [3:0]         out_queue_q;

	assign count_eff = (queue_count_q > CountCap) ? CountCap : queue_count_q;
	assign hash_next = fnv_mix(hash_q, msg_q[MSG_W-1 -: 8]);

	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r = rem_q;
		for (int i = 7; i >= 0; i--) begin
			t = {r, modsh_q[24 + i]};
			if (t >= count_eff) begin
				t = t - count_eff;
			end
			r = t[3:0];
		end
		rem_next = r;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (head_valid) state_d = B_HASH;
			B_HASH: if (left_q == '0) state_d = B_MOD;
			B_MOD:  if (mstep_q == 2'd3) state_d = B_DONE;
			B_DONE: if (!out_valid_q || result.ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		case (state_q)
			B_IDLE: pop = head_valid;
			B_DONE: load = !out_valid_q || result.ready;
			default: begin
				pop  = 1'b0;
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			queue_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				queue_count_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			msg_q   <= head.msg;
			left_q  <= head.v6 ? CNT_W'(V6_BYTES - 1) : CNT_W'(V4_BYTES - 1);
			hash_q  <= FNV_OFFSET;
		end else if (state_q == B_HASH) begin
			msg_q   <= msg_q << 8;
			left_q  <= left_q - 1'b1;
			hash_q  <= hash_next;
			modsh_q <= hash_next;
			rem_q   <= '0;
			mstep_q <= '0;
		end else if (state_q == B_MOD) begin
			modsh_q <= modsh_q << 8;
			rem_q   <= rem_next;
			mstep_q <= mstep_q + 1'b1;
		end
		if (load) begin
			out_hash_q  <= hash_q;
			out_queue_q <= (count_eff == '0) ? 4'd0 : rem_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.tuple_hash = out_hash_q;
	assign result.queue      = out_queue_q;

endmodule

[src/flow_hash_queue_select.sv]
// Top level: FNV-1a flow hash and receive queue select.
// The hash engine takes one tuple at a time: a start state, one hash byte per cycle,
// a modulo reduction and a hand-off into the output slot, which waits while it is full.
// A two-entry job queue lets tuples be taken while the hash engine is busy.
// Reset clears the job queue, the engine state, the output slot and queue_count.
`timescale 1ns / 1ps
module flow_hash_queue_select
	import fhqs_pkg::*;
#(
	parameter int unsigned QueueLimit = QUEUE_LIMIT
)
(
	input  logic          clk,
	input  logic          arst_n,
	fhqs_tuple_if.sink    tuple,
	fhqs_result_if.source result,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_wdata
);

	logic head_valid;
	job_t head;
	logic pop;

	fhqs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tuple      (tuple),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	fhqs_back #(
		.QueueLimit (QueueLimit)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.result     (result)
	);

endmodule

[src/fhqs_checker.sv]
// Port-level assertions for the flow hash queue select block.
`timescale 1ns / 1ps
module fhqs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [4:0]  cfg_wdata,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_hash,
	input logic [3:0]  res_queue
);

	logic [4:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_hash) && $stable(res_queue))
		else $error("result payload changed while stalled");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && count_q == 5'd0 |-> res_queue == 4'd0)
		else $error("queue not zero with zero queue count");

	a_queue_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && count_q != 5'd0 && count_q <= 5'd16 |-> {1'b0, res_queue} < count_q)
		else $error("queue index beyond queue count");

endmodule

bind flow_hash_queue_select fhqs_checker u_fhqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_hash  (result.tuple_hash),
	.res_queue (result.queue)
);
